FILE: sv/channel_pair_mapping_table_defines.svh
// Assertion macros for the channel pair mapping table.
`ifndef CHANNEL_PAIR_MAPPING_TABLE_DEFINES_SVH
`define CHANNEL_PAIR_MAPPING_TABLE_DEFINES_SVH

// Property checked on every rising clock edge out of reset.
`define CPMT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true out of reset.
`define CPMT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: sv/cpmt_pkg.sv
// Types and constants shared by the channel pair mapping table.
`default_nettype none

package cpmt_pkg;

  localparam int ID_W       = 32;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 7;
  localparam int DEF_DEPTH  = 64;
  localparam int DEF_SET    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_LIST_VC = 3'd2,
    MODE_LIST_TC = 3'd3,
    MODE_GETFLAG = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_MISS  = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_TRUNC = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_LAST,
    S_MOVE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0] vc;
    logic [ID_W-1:0] tc;
    logic            flag;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/channel_pair_mapping_table.sv
// Channel pair mapping table: packed pair table with add, remove, list, lookup and clear.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   mode_i, vc_id_i, tc_id_i, cdr_flag_i
//   out      out  out_valid_o / out_ready_i status_o, id_value_o, match_count_o,
//                                           flag_out_o, last_o
//
// Add, remove, flag lookup and list scan the table RAM one entry per cycle while no
// list pause holds the scan; a remove then reads the last entry and writes it over the hit.
// Add, remove and flag searches stop at the first hit. Clear and unused modes skip the scan.
// Reset zeroes the fill count and the control state; entries are not cleared.
// A full output register pauses a list scan when a further match is ready.
`default_nettype none
`include "channel_pair_mapping_table_defines.svh"

module channel_pair_mapping_table #(
  parameter int TABLE_DEPTH = cpmt_pkg::DEF_DEPTH,
  parameter int SET_SIZE    = cpmt_pkg::DEF_SET
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cpmt_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [cpmt_pkg::ID_W-1:0]     vc_id_i,
  input  wire logic [cpmt_pkg::ID_W-1:0]     tc_id_i,
  input  wire logic                          cdr_flag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [cpmt_pkg::STATUS_W-1:0] status_o,
  output logic      [cpmt_pkg::ID_W-1:0]     id_value_o,
  output logic      [cpmt_pkg::CNT_W-1:0]    match_count_o,
  output logic                               flag_out_o,
  output logic                               last_o
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int NW     = $clog2(SET_SIZE + 1);
  localparam int IdW    = cpmt_pkg::ID_W;
  localparam int CntW   = cpmt_pkg::CNT_W;
  localparam int EntryW = $bits(cpmt_pkg::entry_t);

  cpmt_pkg::state_e  state_q, state_d;
  logic [cpmt_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [IdW-1:0]    key_vc_q, key_vc_d;
  logic [IdW-1:0]    key_tc_q, key_tc_d;
  logic              flag_in_q, flag_in_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic              chk_vld_q, chk_vld_d;
  logic [AW-1:0]     chk_idx_q, chk_idx_d;
  logic [AW-1:0]     found_idx_q, found_idx_d;
  logic [NW-1:0]     n_q, n_d;
  logic [IdW-1:0]    pend_id_q, pend_id_d;
  logic              res_flag_q, res_flag_d;
  cpmt_pkg::status_e res_status_q, res_status_d;

  logic              out_valid_q, out_valid_d;
  cpmt_pkg::status_e out_status_q, out_status_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic [CntW-1:0]   out_cnt_q, out_cnt_d;
  logic              out_flag_q, out_flag_d;
  logic              out_last_q, out_last_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  cpmt_pkg::entry_t  wr_entry, rd_entry;
  logic [EntryW-1:0] rd_raw;

  logic              out_free, is_list, by_vc, issuing, hit, stall, scan_end;
  logic              in_scan;
  logic [CW-1:0]     last_idx;

  cpmt_ram #(
    .Width(EntryW),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_raw)
  );

  assign rd_entry = cpmt_pkg::entry_t'(rd_raw);
  assign out_free = !out_valid_q || out_ready_i;
  assign by_vc    = (mode_q == cpmt_pkg::MODE_LIST_VC);
  assign is_list  = by_vc || (mode_q == cpmt_pkg::MODE_LIST_TC);
  assign issuing  = (scan_q < count_q);
  assign last_idx = count_q - CW'(1);
  assign scan_end = !chk_vld_q && !issuing;
  assign in_scan  = (state_q == cpmt_pkg::S_SCAN);

  always_comb begin
    if (is_list) begin
      hit = chk_vld_q && (by_vc ? (rd_entry.vc == key_vc_q) : (rd_entry.tc == key_tc_q));
    end else begin
      hit = chk_vld_q && (rd_entry.vc == key_vc_q) && (rd_entry.tc == key_tc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpmt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      chk_vld_q   <= 1'b0;
      n_q         <= '0;
      scan_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      chk_vld_q   <= chk_vld_d;
      n_q         <= n_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_vc_q     <= key_vc_d;
    key_tc_q     <= key_tc_d;
    flag_in_q    <= flag_in_d;
    chk_idx_q    <= chk_idx_d;
    found_idx_q  <= found_idx_d;
    pend_id_q    <= pend_id_d;
    res_flag_q   <= res_flag_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_cnt_q    <= out_cnt_d;
    out_flag_q   <= out_flag_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    key_vc_d     = key_vc_q;
    key_tc_d     = key_tc_q;
    flag_in_d    = flag_in_q;
    count_d      = count_q;
    scan_d       = scan_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    found_idx_d  = found_idx_q;
    n_d          = n_q;
    pend_id_d    = pend_id_q;
    res_flag_d   = res_flag_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_cnt_d    = out_cnt_q;
    out_flag_d   = out_flag_q;
    out_last_d   = out_last_q;
    in_ready_o   = 1'b0;
    stall        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_raddr    = scan_q[AW-1:0];
    wr_entry     = '{vc: key_vc_q, tc: key_tc_q, flag: flag_in_q};

    unique case (state_q)
      cpmt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d     = mode_i;
          key_vc_d   = vc_id_i;
          key_tc_d   = tc_id_i;
          flag_in_d  = cdr_flag_i;
          scan_d     = '0;
          chk_vld_d  = 1'b0;
          n_d        = '0;
          pend_id_d  = '0;
          res_flag_d = 1'b0;
          unique case (mode_i)
            cpmt_pkg::MODE_ADD, cpmt_pkg::MODE_REMOVE, cpmt_pkg::MODE_LIST_VC,
            cpmt_pkg::MODE_LIST_TC, cpmt_pkg::MODE_GETFLAG: begin
              state_d = cpmt_pkg::S_SCAN;
            end
            cpmt_pkg::MODE_CLEAR: begin
              count_d      = '0;
              res_status_d = cpmt_pkg::STATUS_OK;
              state_d      = cpmt_pkg::S_FINISH;
            end
            default: begin
              res_status_d = cpmt_pkg::STATUS_MISS;
              state_d      = cpmt_pkg::S_FINISH;
            end
          endcase
        end
      end

      cpmt_pkg::S_SCAN: begin
        if (is_list && hit && (n_q == NW'(SET_SIZE))) begin
          res_status_d = cpmt_pkg::STATUS_TRUNC;
          state_d      = cpmt_pkg::S_FINISH;
        end else if (is_list && hit && (n_q != '0) && !out_free) begin
          stall = 1'b1;
        end else if (!is_list && (hit || scan_end)) begin
          // search finished: act on the result
          if (hit) begin
            found_idx_d = chk_idx_q;
          end
          state_d = cpmt_pkg::S_FINISH;
          unique case (mode_q)
            cpmt_pkg::MODE_ADD: begin
              if (hit) begin
                res_status_d = cpmt_pkg::STATUS_MISS;
              end else if (count_q >= CW'(TABLE_DEPTH)) begin
                res_status_d = cpmt_pkg::STATUS_FULL;
              end else begin
                ram_we       = 1'b1;
                count_d      = count_q + CW'(1);
                res_status_d = cpmt_pkg::STATUS_OK;
              end
            end
            cpmt_pkg::MODE_REMOVE: begin
              if (hit) begin
                state_d = cpmt_pkg::S_RD_LAST;
              end else begin
                res_status_d = cpmt_pkg::STATUS_MISS;
              end
            end
            default: begin
              res_status_d = hit ? cpmt_pkg::STATUS_OK : cpmt_pkg::STATUS_MISS;
              res_flag_d   = hit && rd_entry.flag;
            end
          endcase
        end else begin
          if (is_list && hit) begin
            if (n_q != '0) begin
              out_valid_d  = 1'b1;
              out_status_d = cpmt_pkg::STATUS_OK;
              out_id_d     = pend_id_q;
              out_cnt_d    = CntW'(n_q);
              out_flag_d   = 1'b0;
              out_last_d   = 1'b0;
            end
            pend_id_d = by_vc ? rd_entry.tc : rd_entry.vc;
            n_d       = n_q + NW'(1);
          end
          if (issuing) begin
            ram_re    = 1'b1;
            scan_d    = scan_q + CW'(1);
            chk_vld_d = 1'b1;
            chk_idx_d = scan_q[AW-1:0];
          end else begin
            chk_vld_d = 1'b0;
            if (scan_end) begin
              res_status_d = (n_q == '0) ? cpmt_pkg::STATUS_MISS : cpmt_pkg::STATUS_OK;
              state_d      = cpmt_pkg::S_FINISH;
            end
          end
        end
      end

      cpmt_pkg::S_RD_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx[AW-1:0];
        state_d   = cpmt_pkg::S_MOVE;
      end

      cpmt_pkg::S_MOVE: begin
        ram_we       = 1'b1;
        ram_waddr    = found_idx_q;
        wr_entry     = rd_entry;
        count_d      = last_idx;
        res_status_d = cpmt_pkg::STATUS_OK;
        state_d      = cpmt_pkg::S_FINISH;
      end

      cpmt_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = pend_id_q;
          out_cnt_d    = CntW'(n_q);
          out_flag_d   = res_flag_q;
          out_last_d   = 1'b1;
          state_d      = cpmt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cpmt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign id_value_o    = out_id_q;
  assign match_count_o = out_cnt_q;
  assign flag_out_o    = out_flag_q;
  assign last_o        = out_last_q;

  `CPMT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(TABLE_DEPTH), "fill count overflow")
  `CPMT_ASSERT(a_set_bound, clk_i, rst_ni, n_q <= NW'(SET_SIZE), "match count past set size")
  `CPMT_ASSERT(a_scan_bound, clk_i, rst_ni, in_scan |-> (scan_q <= count_q), "scan past fill")
  `CPMT_ASSERT_NEVER(a_stall_list, clk_i, rst_ni, stall && !(is_list && in_scan), "stray stall")

endmodule

`default_nettype wire

FILE: sv/cpmt_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module cpmt_ram #(
  parameter int  Width = 1,
  parameter int  Depth = 2,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: dv/channel_pair_mapping_table_tb.sv
// Testbench for the channel pair mapping table: directed rows, then random traffic.
module channel_pair_mapping_table_tb;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int ID_W         = cpmt_pkg::ID_W;
  localparam int MODE_W       = cpmt_pkg::MODE_W;
  localparam int STATUS_W     = cpmt_pkg::STATUS_W;
  localparam int CNT_W        = cpmt_pkg::CNT_W;
  localparam int DEPTH        = cpmt_pkg::DEF_DEPTH;
  localparam int SET_SZ       = cpmt_pkg::DEF_SET;
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam int LIMIT_CYCLES = 1_000_000;

  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam logic [ID_W-1:0] ID_MAX  = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0] VC_HOT  = 32'hA000_0001;
  localparam logic [ID_W-1:0] VC_ALT  = 32'h0000_F00D;
  localparam logic [ID_W-1:0] TC_BASE = 32'h7000_0000;

  typedef cpmt_pkg::status_e status_e;

  typedef enum int {PH_FILL, PH_CHURN, PH_NOISE} traffic_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   vc;
    logic [ID_W-1:0]   tc;
    logic              fl;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic             flag;
    logic             last;
  } reply_t;

  typedef struct packed {
    req_t    req;
    bit      typed;
    status_e st;
    logic    fo;
  } dir_row_t;

  // typed rows carry a single reply with zero id and count and last set
  localparam dir_row_t DIR_TAB [24] = '{
    '{'{cpmt_pkg::MODE_LIST_VC, 32'h0, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_GETFLAG, ID_MAX, ID_MAX, 1'b1}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{MODE_RSVD6, 32'h1234_5678, 32'h8765_4321, 1'b1}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{MODE_RSVD7, ID_MAX, ID_MAX, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_ADD, 32'h0, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_ADD, ID_MAX, ID_MAX, 1'b1}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_ADD, 32'h0, 32'h0, 1'b1}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_ADD, 32'h0, ID_MAX, 1'b1}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_ADD, ID_MAX, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_ADD, 32'h0, 32'h5A5A_5A5A, 1'b0}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_GETFLAG, ID_MAX, ID_MAX, 1'b0}, 1'b1, cpmt_pkg::STATUS_OK, 1'b1},
    '{'{cpmt_pkg::MODE_GETFLAG, 32'h0, 32'h0, 1'b1}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_GETFLAG, 32'h0, 32'h1, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_LIST_VC, 32'h0, ID_MAX, 1'b0}, 1'b0, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_LIST_TC, 32'h0, ID_MAX, 1'b1}, 1'b0, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_LIST_TC, 32'h0, 32'h1234_5678, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_LIST_VC, 32'h0, 32'h0, 1'b0}, 1'b0, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_GETFLAG, 32'h0, 32'h5A5A_5A5A, 1'b0}, 1'b0, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_CLEAR, ID_MAX, ID_MAX, 1'b1}, 1'b1, cpmt_pkg::STATUS_OK, 1'b0},
    '{'{cpmt_pkg::MODE_LIST_TC, 32'h0, 32'h0, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0},
    '{'{cpmt_pkg::MODE_REMOVE, ID_MAX, ID_MAX, 1'b0}, 1'b1, cpmt_pkg::STATUS_MISS, 1'b0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i      = '0;
  logic [ID_W-1:0]     vc_id_i     = '0;
  logic [ID_W-1:0]     tc_id_i     = '0;
  logic                cdr_flag_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     id_value_o;
  logic [CNT_W-1:0]    match_count_o;
  logic                flag_out_o;
  logic                last_o;

  channel_pair_mapping_table #(
    .TABLE_DEPTH(DEPTH),
    .SET_SIZE   (SET_SZ)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .vc_id_i      (vc_id_i),
    .tc_id_i      (tc_id_i),
    .cdr_flag_i   (cdr_flag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .id_value_o   (id_value_o),
    .match_count_o(match_count_o),
    .flag_out_o   (flag_out_o),
    .last_o       (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow pair table
  logic [ID_W-1:0] tbl_vc   [DEPTH];
  logic [ID_W-1:0] tbl_tc   [DEPTH];
  logic            tbl_flag [DEPTH];
  int              tbl_fill = 0;
  reply_t          reply_q [$];

  int errors     = 0;
  int beats_seen = 0;
  int snd_run    = 0;
  bit snd_calm   = 1'b0;
  int rcv_run    = 0;
  bit rcv_calm   = 1'b0;

  function automatic int find_pair(logic [ID_W-1:0] vc, logic [ID_W-1:0] tc);
    for (int i = 0; i < tbl_fill; i++) begin
      if (tbl_vc[i] == vc && tbl_tc[i] == tc) return i;
    end
    return tbl_fill;
  endfunction

  function automatic void push_single(status_e st, logic fo);
    reply_q.push_back('{status: st, id: '0, cnt: '0, flag: fo, last: 1'b1});
  endfunction

  function automatic void predict_list(bit by_vc, logic [ID_W-1:0] key);
    reply_t hits [SET_SZ];
    int     n;
    bit     more;
    n    = 0;
    more = 1'b0;
    for (int i = 0; i < tbl_fill; i++) begin
      if ((by_vc ? tbl_vc[i] : tbl_tc[i]) != key) continue;
      if (n >= SET_SZ) begin
        more = 1'b1;
        break;
      end
      hits[n] = '{status: cpmt_pkg::STATUS_OK, id: by_vc ? tbl_tc[i] : tbl_vc[i],
                  cnt: CNT_W'(n + 1), flag: 1'b0, last: 1'b0};
      n++;
    end
    if (n == 0) begin
      push_single(cpmt_pkg::STATUS_MISS, 1'b0);
      return;
    end
    hits[n-1].last = 1'b1;
    if (more) hits[n-1].status = cpmt_pkg::STATUS_TRUNC;
    for (int i = 0; i < n; i++) reply_q.push_back(hits[i]);
  endfunction

  function automatic void pair_table_step(req_t r);
    int idx;
    int tail;
    idx = find_pair(r.vc, r.tc);
    case (r.mode)
      cpmt_pkg::MODE_ADD: begin
        if (idx != tbl_fill) begin
          push_single(cpmt_pkg::STATUS_MISS, 1'b0);
        end else if (tbl_fill >= DEPTH) begin
          push_single(cpmt_pkg::STATUS_FULL, 1'b0);
        end else begin
          tbl_vc[tbl_fill]   = r.vc;
          tbl_tc[tbl_fill]   = r.tc;
          tbl_flag[tbl_fill] = r.fl;
          tbl_fill++;
          push_single(cpmt_pkg::STATUS_OK, 1'b0);
        end
      end
      cpmt_pkg::MODE_REMOVE: begin
        if (idx == tbl_fill) begin
          push_single(cpmt_pkg::STATUS_MISS, 1'b0);
        end else begin
          tail          = tbl_fill - 1;
          tbl_vc[idx]   = tbl_vc[tail];
          tbl_tc[idx]   = tbl_tc[tail];
          tbl_flag[idx] = tbl_flag[tail];
          tbl_fill      = tail;
          push_single(cpmt_pkg::STATUS_OK, 1'b0);
        end
      end
      cpmt_pkg::MODE_LIST_VC: predict_list(1'b1, r.vc);
      cpmt_pkg::MODE_LIST_TC: predict_list(1'b0, r.tc);
      cpmt_pkg::MODE_GETFLAG: begin
        if (idx == tbl_fill) push_single(cpmt_pkg::STATUS_MISS, 1'b0);
        else push_single(cpmt_pkg::STATUS_OK, tbl_flag[idx]);
      end
      cpmt_pkg::MODE_CLEAR: begin
        tbl_fill = 0;
        push_single(cpmt_pkg::STATUS_OK, 1'b0);
      end
      default: push_single(cpmt_pkg::STATUS_MISS, 1'b0);
    endcase
  endfunction

  // idle-free stretches are mixed at random with stretches of random gaps
  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 24);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic [ID_W-1:0] pick_vc();
    int w;
    w = $urandom_range(0, 9);
    if (w < 7) return VC_HOT;
    if (w < 9) return VC_ALT;
    return $urandom();
  endfunction

  function automatic logic [ID_W-1:0] pick_tc();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return TC_BASE + $urandom_range(0, 99);
  endfunction

  function automatic req_t make_item(traffic_e ph);
    req_t r;
    int   w;
    int   k;
    r.fl = 1'($urandom_range(0, 1));
    r.vc = pick_vc();
    r.tc = pick_tc();
    w    = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (w < 85)      r.mode = cpmt_pkg::MODE_ADD;
        else if (w < 93) r.mode = cpmt_pkg::MODE_LIST_VC;
        else if (w < 97) r.mode = cpmt_pkg::MODE_LIST_TC;
        else             r.mode = cpmt_pkg::MODE_GETFLAG;
      end
      PH_CHURN: begin
        if (w < 30)      r.mode = cpmt_pkg::MODE_ADD;
        else if (w < 55) r.mode = cpmt_pkg::MODE_REMOVE;
        else if (w < 72) r.mode = cpmt_pkg::MODE_GETFLAG;
        else if (w < 84) r.mode = cpmt_pkg::MODE_LIST_VC;
        else if (w < 94) r.mode = cpmt_pkg::MODE_LIST_TC;
        else if (w < 97) r.mode = cpmt_pkg::MODE_CLEAR;
        else if (w < 99) r.mode = MODE_RSVD6;
        else             r.mode = MODE_RSVD7;
        // aim most lookups at live pairs
        if (tbl_fill > 0 && $urandom_range(0, 3) != 0) begin
          k    = $urandom_range(0, tbl_fill - 1);
          r.vc = tbl_vc[k];
          r.tc = tbl_tc[k];
        end
      end
      default: begin
        r.mode = MODE_W'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) r.vc = $urandom();
        if ($urandom_range(0, 1) == 1) r.tc = $urandom();
      end
    endcase
    return r;
  endfunction

  task automatic drive_item(input req_t r, input bit typed, input status_e st, input logic fo);
    int gap;
    gap = draw_gap(snd_run, snd_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= r.mode;
    vc_id_i    <= r.vc;
    tc_id_i    <= r.tc;
    cdr_flag_i <= r.fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pair_table_step(r);
    if (typed) begin
      void'(reply_q.pop_back());
      push_single(st, fo);
    end
  endtask

  function automatic void cmp_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_beat();
    reply_t want;
    beats_seen++;
    if (reply_q.size() == 0) begin
      errors++;
      $display("%0t: beat with nothing expected, expected none actual status %0h id %0h",
               $time, status_o, id_value_o);
      return;
    end
    want = reply_q.pop_front();
    cmp_field("status", ID_W'(want.status), ID_W'(status_o));
    cmp_field("id_value", want.id, id_value_o);
    cmp_field("match_count", ID_W'(want.cnt), ID_W'(match_count_o));
    cmp_field("flag_out", ID_W'(want.flag), ID_W'(flag_out_o));
    cmp_field("last", ID_W'(want.last), ID_W'(last_o));
  endfunction

  initial begin : stim
    req_t r;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      drive_item(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].st, DIR_TAB[i].fo);
    end
    // fill past capacity with one hot vc so lists truncate, then churn, then noise
    for (int n = 0; n < 100; n++) begin
      r = make_item(PH_FILL);
      drive_item(r, 1'b0, cpmt_pkg::STATUS_OK, 1'b0);
    end
    for (int n = 0; n < 90; n++) begin
      r = make_item(PH_CHURN);
      drive_item(r, 1'b0, cpmt_pkg::STATUS_OK, 1'b0);
    end
    for (int n = 0; n < 60; n++) begin
      r = make_item(PH_NOISE);
      drive_item(r, 1'b0, cpmt_pkg::STATUS_OK, 1'b0);
    end
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("channel_pair_mapping_table verification clean");
    end else begin
      $display("channel_pair_mapping_table verification failed");
    end
    $finish;
  end

  initial begin : sink
    int gap;
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(rcv_run, rcv_calm);
      // one long hold-off so the block backs up into its input
      if (!held && beats_seen >= HOLD_AT_BEAT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_beat();
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("channel_pair_mapping_table verification failed");
    $finish;
  end

endmodule
